>>> rtl/wheel_speed_pi_controller_core_defines.svh
// Assertion macros for the wheel speed PI controller core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef WHEEL_SPEED_PI_CONTROLLER_CORE_DEFINES_SVH
`define WHEEL_SPEED_PI_CONTROLLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define WSPI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wspi check failed");
`define WSPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wspi check failed");
`else
`define WSPI_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define WSPI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/wspi_pkg.sv
// Shared types and constants of the wheel speed PI controller core.
// Depends on nothing; used by every module of the block.
package wspi_pkg;

   localparam int COUNT_W    = 16;
   localparam int TARGET_W   = 32;
   localparam int TOTAL_W    = 40;
   localparam int SCALE_W    = 32;
   localparam int GAIN_W     = 24;
   localparam int ILIM_W     = 31;
   localparam int OLIM_W     = 17;
   localparam int DRIVE_W    = 18;
   localparam int VEL_W      = 32;
   localparam int DIST_W     = 48;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OLIM_W-1:0] OUT_LIMIT_RESET = 17'd39322;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COUNT_SCALE = 3'd0,
      CSR_KP          = 3'd1,
      CSR_KI_DT       = 3'd2,
      CSR_INTEG_LIMIT = 3'd3,
      CSR_OUT_LIMIT   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_KP,
      ST_KI,
      ST_DLO,
      ST_DRV
   } back_state_type;

   typedef struct packed {
      logic [SCALE_W-1:0] count_scale;
      logic [GAIN_W-1:0]  kp;
      logic [GAIN_W-1:0]  ki_dt;
      logic [ILIM_W-1:0]  integ_limit;
      logic [OLIM_W-1:0]  out_limit;
   } cfg_type;

   // One queued tick: total is the count total snapshot, meaningful when take is set
   typedef struct packed {
      logic                take;
      logic [TOTAL_W-1:0]  total;
      logic [TARGET_W-1:0] target;
      logic [COUNT_W-1:0]  count;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic idle;
      logic load;
   } back_status_type;

endpackage

>>> rtl/wspi_front.sv
// Front end: accepts ticks, keeps the saturating count total, tags distance requests.
// Depends on wspi_pkg; feeds wspi_queue.
module wspi_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [wspi_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]                    req_tuser,
   input  wspi_pkg::queue_status_type    q_status,
   output logic                          q_push,
   output wspi_pkg::item_type            q_item
);

   logic signed [wspi_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic signed [wspi_pkg::TOTAL_W:0]   sum_w;
   logic signed [wspi_pkg::TOTAL_W-1:0] sat_w;
   logic [wspi_pkg::COUNT_W-1:0]        count_w;

   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && !q_status.full;
   assign count_w    = req_tdata[wspi_pkg::COUNT_W-1:0];

   assign sum_w = {total_ff[wspi_pkg::TOTAL_W-1], total_ff}
                + {{(wspi_pkg::TOTAL_W + 1 - wspi_pkg::COUNT_W){count_w[wspi_pkg::COUNT_W-1]}},
                   count_w};

   always_comb begin
      if (sum_w[wspi_pkg::TOTAL_W] != sum_w[wspi_pkg::TOTAL_W-1]) begin
         sat_w = sum_w[wspi_pkg::TOTAL_W]
               ? {1'b1, {(wspi_pkg::TOTAL_W-1){1'b0}}}
               : {1'b0, {(wspi_pkg::TOTAL_W-1){1'b1}}};
      end else begin
         sat_w = sum_w[wspi_pkg::TOTAL_W-1:0];
      end
   end

   always_comb begin
      q_item.count  = count_w;
      q_item.target = req_tdata[wspi_pkg::REQ_DATA_W-1:wspi_pkg::COUNT_W];
      q_item.take   = req_tuser[0];
      q_item.total  = sat_w;
   end

   // drop the total once it has been handed on with a distance request
   always_comb begin
      total_in = total_ff;
      if (q_push) begin
         total_in = req_tuser[0] ? '0 : sat_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

endmodule

>>> rtl/wspi_queue.sv
// Small register queue between the front and back ends.
// Depends on wspi_pkg for the item type.
module wspi_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  wspi_pkg::item_type         push_item,
   input  logic                       pop,
   output wspi_pkg::item_type         head_item,
   output wspi_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wspi_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/wspi_mul.sv
// Shared signed multiplier with a registered product.
// Depends on wspi_pkg for operand widths; used by wspi_back.
module wspi_mul (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [wspi_pkg::MUL_W-1:0]   a,
   input  logic signed [wspi_pkg::MUL_W-1:0]   b,
   output logic signed [wspi_pkg::PROD_W-1:0]  p
);

   logic signed [wspi_pkg::PROD_W-1:0] p_ff, p_in;

   assign p_in = a * b;
   assign p    = p_ff;

   // hold the product while disabled so the last step can wait on the output
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

endmodule

>>> rtl/wspi_back.sv
// Back end: sequences one tick through the shared multiplier and owns the integrator
// and the result register. Depends on wspi_pkg and wspi_mul.
module wspi_back (
   input  logic                              clock,
   input  logic                              reset,
   input  wspi_pkg::cfg_type                 cfg,
   input  wspi_pkg::queue_status_type        q_status,
   input  wspi_pkg::item_type                q_item,
   output logic                              q_pop,
   output wspi_pkg::back_status_type         status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [wspi_pkg::DRIVE_W-1:0]      rsp_drive,
   output logic [wspi_pkg::VEL_W-1:0]        rsp_velocity,
   output logic [wspi_pkg::DIST_W-1:0]       rsp_distance,
   output logic                              rsp_distance_valid
);

   localparam int DSUM_W = 57;
   localparam int WSUM_W = 41;

   wspi_pkg::back_state_type state_ff, state_in;

   wspi_pkg::item_type                   work_ff, work_in;
   logic signed [wspi_pkg::VEL_W-1:0]    vel_ff, vel_in;
   logic signed [31:0]                   err_ff, err_in;
   logic signed [55:0]                   dhi_ff, dhi_in;
   logic signed [39:0]                   pterm_ff, pterm_in;
   logic signed [31:0]                   integ_ff, integ_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [wspi_pkg::DRIVE_W-1:0]         rsp_drive_ff, rsp_drive_in;
   logic [wspi_pkg::VEL_W-1:0]           rsp_vel_ff, rsp_vel_in;
   logic [wspi_pkg::DIST_W-1:0]          rsp_dist_ff, rsp_dist_in;
   logic                                 rsp_dval_ff, rsp_dval_in;

   logic                                 mul_en;
   logic signed [wspi_pkg::MUL_W-1:0]    mul_a, mul_b;
   logic signed [wspi_pkg::PROD_W-1:0]   prod;
   logic                                 out_free, out_load;

   logic signed [32:0]                   diff_w;
   logic signed [31:0]                   err_w;
   logic signed [39:0]                   iterm_w;
   logic signed [WSUM_W-1:0]             isum_w, ilim_w, iclamp_w;
   logic signed [WSUM_W-1:0]             dsum_w, olim_w, dclamp_w;
   logic signed [DSUM_W-1:0]             xsum_w;
   logic [wspi_pkg::DIST_W-1:0]          xsat_w;

   wspi_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wspi_pkg::ST_IDLE: if (!q_status.empty) state_in = wspi_pkg::ST_ERR;
         wspi_pkg::ST_ERR:  state_in = wspi_pkg::ST_KP;
         wspi_pkg::ST_KP:   state_in = wspi_pkg::ST_KI;
         wspi_pkg::ST_KI:   state_in = wspi_pkg::ST_DLO;
         wspi_pkg::ST_DLO:  state_in = wspi_pkg::ST_DRV;
         wspi_pkg::ST_DRV:  if (out_free) state_in = wspi_pkg::ST_IDLE;
         default:           state_in = wspi_pkg::ST_IDLE;
      endcase
   end

   // multiplier operands and control per step
   always_comb begin
      mul_en   = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      q_pop    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         wspi_pkg::ST_IDLE: begin
            mul_en = !q_status.empty;
            q_pop  = !q_status.empty;
            mul_a  = {{(wspi_pkg::MUL_W - wspi_pkg::COUNT_W){q_item.count[15]}}, q_item.count};
            mul_b  = {1'b0, cfg.count_scale};
         end
         wspi_pkg::ST_ERR: begin
            mul_en = 1'b1;
            mul_a  = {{9{work_ff.total[39]}}, work_ff.total[39:16]};
            mul_b  = {1'b0, cfg.count_scale};
         end
         wspi_pkg::ST_KP: begin
            mul_en = 1'b1;
            mul_a  = {err_ff[31], err_ff};
            mul_b  = {9'b0, cfg.kp};
         end
         wspi_pkg::ST_KI: begin
            mul_en = 1'b1;
            mul_a  = {err_ff[31], err_ff};
            mul_b  = {9'b0, cfg.ki_dt};
         end
         wspi_pkg::ST_DLO: begin
            mul_en = 1'b1;
            mul_a  = {17'b0, work_ff.total[15:0]};
            mul_b  = {1'b0, cfg.count_scale};
         end
         wspi_pkg::ST_DRV: begin
            out_load = out_free;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // error: target minus measured speed, saturated to 32 bits
   assign diff_w = {work_ff.target[31], work_ff.target} - {prod[47], prod[47:16]};
   always_comb begin
      if (diff_w[32] != diff_w[31]) begin
         err_w = diff_w[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
         err_w = diff_w[31:0];
      end
   end

   // integrator step, clamped to plus or minus integ_limit
   assign iterm_w = prod[55:16];
   assign isum_w  = {{9{integ_ff[31]}}, integ_ff} + {iterm_w[39], iterm_w};
   assign ilim_w  = {10'b0, cfg.integ_limit};
   always_comb begin
      if (isum_w > ilim_w) begin
         iclamp_w = ilim_w;
      end else if (isum_w < -ilim_w) begin
         iclamp_w = -ilim_w;
      end else begin
         iclamp_w = isum_w;
      end
   end

   // drive: proportional term plus integrator, clamped to plus or minus out_limit
   assign dsum_w = {pterm_ff[39], pterm_ff} + {{9{integ_ff[31]}}, integ_ff};
   assign olim_w = {24'b0, cfg.out_limit};
   always_comb begin
      if (dsum_w > olim_w) begin
         dclamp_w = olim_w;
      end else if (dsum_w < -olim_w) begin
         dclamp_w = -olim_w;
      end else begin
         dclamp_w = dsum_w;
      end
   end

   // distance: high part product plus floored low part product, saturated to 48 bits
   assign xsum_w = {dhi_ff[55], dhi_ff} + {25'b0, prod[47:16]};
   always_comb begin
      if (xsum_w[DSUM_W-1:wspi_pkg::DIST_W-1] != {(DSUM_W - wspi_pkg::DIST_W + 1){1'b0}}
          && xsum_w[DSUM_W-1:wspi_pkg::DIST_W-1] != {(DSUM_W - wspi_pkg::DIST_W + 1){1'b1}})
      begin
         xsat_w = xsum_w[DSUM_W-1] ? {1'b1, {(wspi_pkg::DIST_W-1){1'b0}}}
                                    : {1'b0, {(wspi_pkg::DIST_W-1){1'b1}}};
      end else begin
         xsat_w = xsum_w[wspi_pkg::DIST_W-1:0];
      end
   end

   always_comb begin
      work_in      = work_ff;
      vel_in       = vel_ff;
      err_in       = err_ff;
      dhi_in       = dhi_ff;
      pterm_in     = pterm_ff;
      integ_in     = integ_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_dval_in  = rsp_dval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (q_pop) begin
         work_in = q_item;
      end
      case (state_ff)
         wspi_pkg::ST_ERR: begin
            vel_in = prod[47:16];
            err_in = err_w;
         end
         wspi_pkg::ST_KP:  dhi_in   = prod[55:0];
         wspi_pkg::ST_KI:  pterm_in = prod[55:16];
         wspi_pkg::ST_DLO: integ_in = iclamp_w[31:0];
         default: begin
            dhi_in = dhi_ff;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_drive_in = dclamp_w[wspi_pkg::DRIVE_W-1:0];
         rsp_vel_in   = vel_ff;
         rsp_dist_in  = work_ff.take ? xsat_w : '0;
         rsp_dval_in  = work_ff.take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wspi_pkg::ST_IDLE;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      vel_ff       <= vel_in;
      err_ff       <= err_in;
      dhi_ff       <= dhi_in;
      pterm_ff     <= pterm_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_dval_ff  <= rsp_dval_in;
   end

   assign status.idle        = (state_ff == wspi_pkg::ST_IDLE);
   assign status.load        = out_load;
   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_drive          = rsp_drive_ff;
   assign rsp_velocity       = rsp_vel_ff;
   assign rsp_distance       = rsp_dist_ff;
   assign rsp_distance_valid = rsp_dval_ff;

endmodule

>>> rtl/wheel_speed_pi_controller_core.sv
// Each transaction takes five passes through the one shared 33x33 multiplier plus a
// final add-and-clamp step in the back end, which then waits for the output register
// to be free; the back end takes a new transaction only after the last has been loaded.
// The front end keeps taking up to QUEUE_DEPTH transactions ahead of the back end.
// Reset (synchronous, active high) clears integrator, count total, queue and output,
// and returns the registers to their defaults (out_limit 0.6, all others zero).
`include "wheel_speed_pi_controller_core_defines.svh"

module wheel_speed_pi_controller_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // encoder_count [15:0], target_velocity [47:16]
   input  logic [wspi_pkg::REQ_DATA_W-1:0] req_tdata,
   // take_distance [0]
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // drive [17:0], velocity [49:18], distance [97:50], zero [103:98]
   output logic [wspi_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // distance_valid [0]
   output logic [0:0]                      rsp_tuser,
   input  logic                            csr_we,
   input  logic [wspi_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [wspi_pkg::CSR_DATA_W-1:0] csr_wdata
);

   wspi_pkg::cfg_type                cfg_ff, cfg_in;
   wspi_pkg::queue_status_type       q_status;
   wspi_pkg::back_status_type        back_status;
   wspi_pkg::item_type               push_item, head_item;
   logic                             q_push, q_pop;
   logic [wspi_pkg::DRIVE_W-1:0]     rsp_drive;
   logic [wspi_pkg::VEL_W-1:0]       rsp_velocity;
   logic [wspi_pkg::DIST_W-1:0]      rsp_distance;
   logic                             rsp_distance_valid;
   logic signed [wspi_pkg::DRIVE_W-1:0] drive_chk, olim_chk;
   logic                             drive_in_clamp;

   // Register writes are taken at once; software must write only while the block is idle,
   // which the block itself does not enforce. Indexes beyond the register list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (wspi_pkg::csr_index_type'(csr_addr))
            wspi_pkg::CSR_COUNT_SCALE: cfg_in.count_scale = csr_wdata;
            wspi_pkg::CSR_KP:          cfg_in.kp          = csr_wdata[wspi_pkg::GAIN_W-1:0];
            wspi_pkg::CSR_KI_DT:       cfg_in.ki_dt       = csr_wdata[wspi_pkg::GAIN_W-1:0];
            wspi_pkg::CSR_INTEG_LIMIT: cfg_in.integ_limit = csr_wdata[wspi_pkg::ILIM_W-1:0];
            wspi_pkg::CSR_OUT_LIMIT:   cfg_in.out_limit   = csr_wdata[wspi_pkg::OLIM_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_scale <= '0;
         cfg_ff.kp          <= '0;
         cfg_ff.ki_dt       <= '0;
         cfg_ff.integ_limit <= '0;
         cfg_ff.out_limit   <= wspi_pkg::OUT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accept, accumulate the count total, tag distance requests.
   wspi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   // Decouple the two ends so each can stall on its own.
   wspi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   // Back end: multiply, integrate, clamp and hold the result until taken.
   wspi_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_status           (q_status),
      .q_item             (head_item),
      .q_pop              (q_pop),
      .status             (back_status),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_drive          (rsp_drive),
      .rsp_velocity       (rsp_velocity),
      .rsp_distance       (rsp_distance),
      .rsp_distance_valid (rsp_distance_valid)
   );

   assign rsp_tdata = {6'b0, rsp_distance, rsp_velocity, rsp_drive};
   assign rsp_tuser = rsp_distance_valid;

   assign drive_chk      = rsp_drive;
   assign olim_chk       = {1'b0, cfg_ff.out_limit};
   assign drive_in_clamp = (drive_chk <= olim_chk) && (drive_chk >= -olim_chk);

   // A result without a distance report carries a zero distance.
   `WSPI_ASSERT_NOW(a_dist_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_distance == '0)
   // The presented drive never leaves the output clamp.
   `WSPI_ASSERT_NOW(a_drive_clamp, clock, reset, rsp_tvalid, drive_in_clamp)
   // An idle back end with queued work starts on it in the next cycle.
   `WSPI_ASSERT_NEXT(a_back_starts, clock, reset, back_status.idle && !q_status.empty, !back_status.idle)
   // A load into the output register always leaves a valid result behind.
   `WSPI_ASSERT_NEXT(a_load_valid, clock, reset, back_status.load, rsp_tvalid)

endmodule
